### rtl/core/ssr_pkg.sv
`default_nettype none

package ssr_pkg;

  // Fixed field widths of the stream and configuration port
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_W    = 5;
  localparam int CMD_W     = 2;

  // Input item kinds, carried on s_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_PATH    = 2'd0,
    CMD_SEARCH  = 2'd1,
    CMD_REPLACE = 2'd2
  } ssr_cmd_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN = 1'b1;

  // Per-cell controls driven by the top level
  typedef struct packed {
    logic append;     // take the incoming character into this cell
    logic shift;      // take the right neighbor's value
    logic search_we;  // load this cell's pattern character
  } ssr_cell_ctrl_t;

  // Burst sequencer states
  typedef enum logic [1:0] {
    BURST_IDLE,
    BURST_REPLACE,
    BURST_FLUSH
  } ssr_burst_t;

endpackage

`default_nettype wire

### rtl/core/stream_substring_replacer_top.sv
// Output: once the window holds search_length characters, a non-matching transfer moves
//   the oldest one into the output queue; pass-through (search_length 0) pushes the input.
// Throughput: one character per cycle while the queue has room, set by the compare across
//   cells; a match or the last character holds input off for its burst of up to 32 outputs.
// Reset (synchronous, rst high): lengths, window fill, replace flag, burst and queue clear;
//   search and replacement tables are undefined until loaded.
`default_nettype none

module stream_substring_replacer_top import ssr_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int REPLACE_MAX = 32,
  parameter int CHAR_BITS   = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  // slot, char_in (from bit 0 up), zero filled to bytes
  input  wire logic [((SLOT_W + CHAR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // command
  input  wire logic [CMD_W-1:0]                          s_tuser,
  input  wire logic                                      s_tlast,
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  // char_out, zero filled to bytes
  output logic      [((CHAR_BITS + 7) / 8) * 8 - 1:0]    m_tdata,
  // any_replaced
  output logic                                           m_tuser,
  output logic                                           m_tlast,
  input  wire logic                                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                      cfg_index,
  input  wire logic [CFG_W-1:0]                          cfg_data
);

  localparam int OUT_W   = ((CHAR_BITS + 7) / 8) * 8;
  localparam int MAX_LEN = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int RI_W    = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;
  localparam int Q_W     = CHAR_BITS + 2;

  // Registers and their next values
  logic [CFG_W-1:0] search_length;
  logic [CFG_W-1:0] replace_length;
  logic [CNT_W-1:0] fill;
  logic             seen;
  ssr_burst_t       state;
  ssr_burst_t       state_next;
  logic [CNT_W-1:0] remain;
  logic [RI_W-1:0]  rep_idx;
  logic [RI_W-1:0]  rep_idx_next;
  logic             burst_last;
  logic             burst_seen;

  // Input fields
  logic [SLOT_W-1:0]    slot;
  logic [CHAR_BITS-1:0] ch;
  logic                 s_fire;
  logic                 path;

  // Window datapath
  logic [CNT_W-1:0]     slen_eff;
  logic [CNT_W-1:0]     rlen_eff;
  logic [CNT_W-1:0]     fill_app;
  logic                 append_on;
  logic                 window_full;
  logic                 match;
  logic                 hit;
  logic                 miss_shift;
  logic                 burst_shift;
  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] active;
  logic [CHAR_BITS-1:0] cand [PATTERN_MAX];
  ssr_cell_ctrl_t       cell_ctrl [PATTERN_MAX];
  logic [CHAR_BITS-1:0] rep_rdata;

  // Output queue
  logic                 push;
  logic [CHAR_BITS-1:0] push_char;
  logic                 push_last;
  logic                 push_any;
  logic                 q_full;
  logic [Q_W-1:0]       q_data;

  assign slot   = s_tdata[SLOT_W-1:0];
  assign ch     = s_tdata[SLOT_W +: CHAR_BITS];
  assign s_fire = s_tvalid && s_tready;
  assign path   = s_fire && (s_tuser == CMD_PATH);

  assign s_tready = (state == BURST_IDLE) && !q_full;

  // Lengths above the table depth act as the depth
  always_comb begin
    if (int'(search_length) > PATTERN_MAX) begin
      slen_eff = CNT_W'(PATTERN_MAX);
    end else begin
      slen_eff = CNT_W'(search_length);
    end
    if (int'(replace_length) > REPLACE_MAX) begin
      rlen_eff = CNT_W'(REPLACE_MAX);
    end else begin
      rlen_eff = CNT_W'(replace_length);
    end
  end

  // Window fill and compare decisions
  assign append_on   = path && (slen_eff != '0) && (fill < slen_eff);
  assign fill_app    = fill + CNT_W'(append_on);
  assign window_full = (slen_eff != '0) && (fill_app == slen_eff);
  assign match       = &(eq | ~active);
  assign hit         = path && window_full && match;
  assign miss_shift  = path && window_full && !match && !s_tlast;
  assign burst_shift = (state == BURST_FLUSH) && !q_full;

  // Row of window cells; cell 0 is the oldest character
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [CHAR_BITS-1:0] right;

    if (i == PATTERN_MAX - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = cand[i+1];
    end

    assign active[i]           = (CNT_W'(i) < slen_eff);
    assign cell_ctrl[i].append = append_on && (fill == CNT_W'(i));
    assign cell_ctrl[i].shift  = miss_shift || burst_shift;
    assign cell_ctrl[i].search_we = s_fire && (s_tuser == CMD_SEARCH) && (int'(slot) == i);

    ssr_cell #(
      .CHAR_BITS (CHAR_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .char_in   (ch),
      .next_cand (right),
      .cand      (cand[i]),
      .eq        (eq[i])
    );
  end

  // Replacement read index, given as the next value to the registered table read
  always_comb begin
    if ((state == BURST_IDLE) && (state_next != BURST_IDLE)) begin
      rep_idx_next = '0;
    end else if ((state != BURST_IDLE) && !q_full) begin
      rep_idx_next = rep_idx + RI_W'(1);
    end else begin
      rep_idx_next = rep_idx;
    end
  end

  // Replacement string storage
  ssr_replace_table #(
    .REPLACE_MAX (REPLACE_MAX),
    .CHAR_BITS   (CHAR_BITS),
    .IDX_W       (RI_W)
  ) u_replace_table (
    .clk    (clk),
    .we     (s_fire && (s_tuser == CMD_REPLACE)),
    .slot   (slot),
    .wdata  (ch),
    .rd_idx (rep_idx_next),
    .rdata  (rep_rdata)
  );

  // Burst sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      BURST_IDLE: begin
        if (hit && (rlen_eff != '0)) begin
          state_next = BURST_REPLACE;
        end else if (path && s_tlast && (slen_eff != '0) && !hit && (fill_app != '0)) begin
          state_next = BURST_FLUSH;
        end
      end
      BURST_REPLACE, BURST_FLUSH: begin
        if (!q_full && (remain == CNT_W'(1))) begin
          state_next = BURST_IDLE;
        end
      end
      default: state_next = BURST_IDLE;
    endcase
  end

  // Burst sequencer: outputs into the queue
  always_comb begin
    push      = 1'b0;
    push_char = '0;
    push_last = 1'b0;
    push_any  = 1'b0;
    case (state)
      BURST_IDLE: begin
        if (path) begin
          if (slen_eff == '0) begin
            // pass-through
            push      = 1'b1;
            push_char = ch;
            push_last = s_tlast;
            push_any  = s_tlast && seen;
          end else if (miss_shift) begin
            push      = 1'b1;
            push_char = cand[0];
          end else if (s_tlast && (hit ? (rlen_eff == '0) : (fill_app == '0))) begin
            // empty rewritten path: end marker only
            push      = 1'b1;
            push_last = 1'b1;
            push_any  = seen || hit;
          end
        end
      end
      BURST_REPLACE: begin
        if (!q_full) begin
          push      = 1'b1;
          push_char = rep_rdata;
          push_last = burst_last && (remain == CNT_W'(1));
          push_any  = burst_last && (remain == CNT_W'(1)) && burst_seen;
        end
      end
      BURST_FLUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          push_char = cand[0];
          push_last = burst_last && (remain == CNT_W'(1));
          push_any  = burst_last && (remain == CNT_W'(1)) && burst_seen;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_length  <= '0;
      replace_length <= '0;
      fill           <= '0;
      seen           <= 1'b0;
      state          <= BURST_IDLE;
      remain         <= '0;
      rep_idx        <= '0;
      burst_last     <= 1'b0;
      burst_seen     <= 1'b0;
    end else begin
      state   <= state_next;
      rep_idx <= rep_idx_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_SEARCH_LEN:  search_length  <= cfg_data;
          REG_REPLACE_LEN: replace_length <= cfg_data;
          default: ;
        endcase
      end

      // new search length drops the window
      if (cfg_we && (cfg_index == REG_SEARCH_LEN)) begin
        fill <= '0;
      end else if (path && (slen_eff != '0)) begin
        if (hit || s_tlast) begin
          fill <= '0;
        end else if (miss_shift) begin
          fill <= fill_app - CNT_W'(1);
        end else begin
          fill <= fill_app;
        end
      end

      if (path) begin
        if (s_tlast) begin
          seen <= 1'b0;
        end else if (hit) begin
          seen <= 1'b1;
        end
      end

      // burst counters
      if ((state == BURST_IDLE) && (state_next != BURST_IDLE)) begin
        remain     <= (state_next == BURST_REPLACE) ? rlen_eff : fill_app;
        burst_last <= s_tlast;
        burst_seen <= seen || hit;
      end else if ((state != BURST_IDLE) && !q_full) begin
        remain <= remain - CNT_W'(1);
      end
    end
  end

  // Output register pair parts the input side from the sink
  ssr_out_queue #(
    .WIDTH (Q_W)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_any, push_last, push_char}),
    .pop       (m_tready),
    .full      (q_full),
    .valid     (m_tvalid),
    .data      (q_data)
  );

  assign m_tdata = OUT_W'(q_data[CHAR_BITS-1:0]);
  assign m_tlast = q_data[CHAR_BITS];
  assign m_tuser = q_data[CHAR_BITS+1];

endmodule

`default_nettype wire

### rtl/core/ssr_cell.sv
`default_nettype none

module ssr_cell import ssr_pkg::*; #(
  parameter int CHAR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire ssr_cell_ctrl_t       ctrl,
  input  wire logic [CHAR_BITS-1:0] char_in,
  input  wire logic [CHAR_BITS-1:0] next_cand,
  output logic      [CHAR_BITS-1:0] cand,
  output logic                      eq
);

  logic [CHAR_BITS-1:0] win;
  logic [CHAR_BITS-1:0] pattern;

  // Window value as it stands after this cycle's append
  assign cand = ctrl.append ? char_in : win;
  assign eq   = (cand == pattern);

  // Window slot: hold/append, or move one place toward the head
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win <= next_cand;
    end else begin
      win <= cand;
    end
  end

  // Search pattern character
  always_ff @(posedge clk) begin
    if (ctrl.search_we) begin
      pattern <= char_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssr_replace_table.sv
`default_nettype none

module ssr_replace_table import ssr_pkg::*; #(
  parameter int REPLACE_MAX = 32,
  parameter int CHAR_BITS   = 16,
  parameter int IDX_W       = 5
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [SLOT_W-1:0]    slot,
  input  wire logic [CHAR_BITS-1:0] wdata,
  input  wire logic [IDX_W-1:0]     rd_idx,
  output logic      [CHAR_BITS-1:0] rdata
);

  logic [CHAR_BITS-1:0] entries [REPLACE_MAX];

  // Slots beyond the table never match an entry and are dropped
  always_ff @(posedge clk) begin
    for (int i = 0; i < REPLACE_MAX; i++) begin
      if (we && (int'(slot) == i)) begin
        entries[i] <= wdata;
      end
    end
  end

  // Registered read; the caller presents the next index
  always_ff @(posedge clk) begin
    rdata <= entries[rd_idx];
  end

endmodule

`default_nettype wire

### rtl/core/ssr_out_queue.sv
`default_nettype none

module ssr_out_queue #(
  parameter int WIDTH = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  valid,
  output logic      [WIDTH-1:0] data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop_fire;

  assign pop_fire = pop && valid;
  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign data     = slots[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_fire) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop_fire);
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssr_checker.sv
`default_nettype none

module ssr_checker #(
  parameter int CHAR_BITS = 16
) (
  input wire logic                                   clk,
  input wire logic                                   rst,
  input wire logic                                   m_tvalid,
  input wire logic                                   m_tready,
  input wire logic [((CHAR_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input wire logic                                   m_tuser,
  input wire logic                                   m_tlast
);

  // Replace flag only travels on the final character of a path
  a_flag_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !m_tuser)
    else $error("any_replaced set on a non-final transfer");

  // Output queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("output valid right after reset");

  // Stalled output holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("output changed while stalled");

endmodule

bind stream_substring_replacer_top ssr_checker #(
  .CHAR_BITS (CHAR_BITS)
) u_ssr_checker (.*);

`default_nettype wire

### tb/sv/stream_substring_replacer_top_tb.sv
`timescale 1ns / 1ps

module stream_substring_replacer_top_tb;
  import ssr_pkg::*;

  localparam int TAB_DEPTH     = 32;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_CYCLES  = 250;
  localparam int NUM_SEGS      = 7;

  // command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [15:0] CH_A = 16'h0041;
  localparam logic [15:0] CH_B = 16'h0042;
  localparam logic [15:0] CH_C = 16'h0043;
  localparam logic [15:0] CH_X = 16'h0058;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       ch;
    logic              last;
  } path_item_t;

  typedef struct packed {
    logic [15:0] ch;
    logic        last;
    logic        replaced;
  } out_char_t;

  typedef enum logic {ROW_XFER, ROW_REG} row_kind_t;

  // one line of the directed table; fixed_n < 0 means use the predictor
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    path_item_t            item;
    int                    fixed_n;
    out_char_t             fixed_res;
  } stim_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [23:0]            s_tdata   = '0;
  logic [CMD_W-1:0]       s_tuser   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [15:0]            m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data  = '0;

  stream_substring_replacer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow state of the rewriter
  logic [15:0]     pat_tab [TAB_DEPTH];
  logic [15:0]     sub_tab [TAB_DEPTH];
  logic [15:0]     win     [TAB_DEPTH];
  int              win_fill;
  logic            seen_sub;
  logic [CFG_W-1:0] pat_len;
  logic [CFG_W-1:0] sub_len;

  out_char_t       step_out[$];
  out_char_t       rewrite_q[$];
  stim_row_t       dir_rows[$];

  int send_idle = 0;
  int recv_idle = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int stall_left = 0;

  int mismatches = 0;
  int items_sent = 0;
  int chars_checked = 0;
  int paths_seen = 0;
  int replaced_paths = 0;

  function automatic int clamp_len(input logic [CFG_W-1:0] v);
    return (v > TAB_DEPTH) ? TAB_DEPTH : int'(v);
  endfunction

  // Expected output characters of one input transfer, left in step_out
  function automatic void predict_rewrite(input path_item_t it);
    int        plen;
    int        rlen;
    int        i;
    logic      hit;
    out_char_t tail;
    step_out.delete();
    if (it.cmd == CMD_SEARCH) begin
      pat_tab[it.slot] = it.ch;
    end else if (it.cmd == CMD_REPLACE) begin
      sub_tab[it.slot] = it.ch;
    end else if (it.cmd == CMD_PATH) begin
      plen = clamp_len(pat_len);
      rlen = clamp_len(sub_len);
      if (plen == 0) begin
        step_out.push_back('{it.ch, 1'b0, 1'b0});
      end else begin
        if (win_fill < plen) begin
          win[win_fill] = it.ch;
          win_fill++;
        end
        if (win_fill >= plen) begin
          hit = 1'b1;
          for (i = 0; i < plen; i++)
            if (win[i] != pat_tab[i]) hit = 1'b0;
          if (hit) begin
            for (i = 0; i < rlen; i++) step_out.push_back('{sub_tab[i], 1'b0, 1'b0});
            win_fill = 0;
            seen_sub = 1'b1;
          end else begin
            step_out.push_back('{win[0], 1'b0, 1'b0});
            for (i = 1; i < win_fill; i++) win[i-1] = win[i];
            win_fill--;
          end
        end
        // flush what is left in the window at end of path
        if (it.last) begin
          for (i = 0; i < win_fill; i++) step_out.push_back('{win[i], 1'b0, 1'b0});
          win_fill = 0;
        end
      end
      if (it.last) begin
        // an empty rewritten path still gets an end marker
        if (step_out.size() == 0) step_out.push_back('{16'h0000, 1'b0, 1'b0});
        tail = step_out.pop_back();
        tail.last = 1'b1;
        tail.replaced = seen_sub;
        step_out.push_back(tail);
        seen_sub = 1'b0;
        paths_seen++;
      end
    end
  endfunction

  function automatic stim_row_t xfer_row(input logic [CMD_W-1:0] cmd,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [15:0] ch, input logic last,
                                         input int fixed_n, input out_char_t fixed_res);
    stim_row_t row;
    row.kind      = ROW_XFER;
    row.reg_idx   = '0;
    row.reg_val   = '0;
    row.item      = '{cmd, slot, ch, last};
    row.fixed_n   = fixed_n;
    row.fixed_res = fixed_res;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    stim_row_t row;
    row.kind      = ROW_REG;
    row.reg_idx   = idx;
    row.reg_val   = val;
    row.item      = '0;
    row.fixed_n   = -1;
    row.fixed_res = '0;
    return row;
  endfunction

  // Mostly the two pattern letters, sometimes the code extremes or anything
  function automatic logic [15:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1) ? CH_A : CH_B;
    if (r < 90) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // One input transfer; expectations are queued once it is accepted
  task automatic send_item(input path_item_t it, input int fixed_n, input out_char_t fixed_res);
    int k;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {3'b000, it.ch, it.slot};
    s_tlast  <= it.last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_rewrite(it);
    if (fixed_n < 0) begin
      for (k = 0; k < step_out.size(); k++) rewrite_q.push_back(step_out[k]);
    end else if (fixed_n == 1) begin
      rewrite_q.push_back(fixed_res);
    end
  endtask

  // Drain all expected output, then let the block settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEARCH_LEN) begin
      pat_len  = val;
      win_fill = 0;
    end else begin
      sub_len = val;
    end
  endtask

  // One path built from pattern copies, broken prefixes and loose characters
  task automatic send_path(output int n_sent);
    logic [15:0] chars[$];
    path_item_t  it;
    int          plen;
    int          pieces;
    int          r;
    int          cut;
    int          p;
    int          k;
    plen   = clamp_len(pat_len);
    pieces = (plen > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4);
    for (p = 0; p < pieces; p++) begin
      r = $urandom_range(99);
      if (plen > 0 && r < 45) begin
        for (k = 0; k < plen; k++) chars.push_back(pat_tab[k]);
      end else if (plen > 1 && r < 60) begin
        cut = $urandom_range(1, plen - 1);
        for (k = 0; k < cut; k++) chars.push_back(pat_tab[k]);
      end else begin
        cut = $urandom_range(1, 3);
        for (k = 0; k < cut; k++) chars.push_back(pick_char());
      end
    end
    for (k = 0; k < chars.size(); k++) begin
      // occasional unused command mixed into the path
      if ($urandom_range(99) < 6) begin
        it = '{CMD_UNUSED, 5'($urandom), 16'($urandom), 1'($urandom)};
        send_item(it, -1, '0);
      end
      it = '{CMD_PATH, 5'($urandom), chars[k], k == chars.size() - 1};
      send_item(it, -1, '0);
    end
    n_sent = chars.size();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial forever @(posedge clk) begin
    if (stall_requests != stall_served) begin
      stall_served = stall_requests;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Output checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    out_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (rewrite_q.size() == 0) begin
        $error("unexpected output transfer: char_out %h last %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = rewrite_q.pop_front();
        if (m_tdata != want.ch) begin
          $error("char_out: expected %h, got %h", want.ch, m_tdata);
          mismatches++;
        end
        if (m_tlast != want.last) begin
          $error("out_last: expected %b, got %b", want.last, m_tlast);
          mismatches++;
        end
        if (m_tuser != want.replaced) begin
          $error("any_replaced: expected %b, got %b", want.replaced, m_tuser);
          mismatches++;
        end
        chars_checked++;
        if (m_tlast && m_tuser) replaced_paths++;
      end
    end
  end

  initial begin : main_seq
    int         i;
    int         seg;
    int         used;
    int         n;
    int         seg_pat    [NUM_SEGS];
    int         seg_sub    [NUM_SEGS];
    int         seg_budget [NUM_SEGS];
    path_item_t it;

    for (i = 0; i < TAB_DEPTH; i++) begin
      pat_tab[i] = '0;
      sub_tab[i] = '0;
      win[i]     = '0;
    end
    win_fill = 0;
    seen_sub = 1'b0;
    pat_len  = '0;
    sub_len  = '0;

    // Directed table
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd31, 16'hFFFF, 1'b0, 1, '{16'hFFFF, 1'b0, 1'b0}));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, 16'h0000, 1'b1, 1, '{16'h0000, 1'b1, 1'b0}));
    dir_rows.push_back(xfer_row(CMD_UNUSED, 5'd31, 16'hFFFF, 1'b1, 0, '0));
    dir_rows.push_back(xfer_row(CMD_SEARCH, 5'd0, CH_A, 1'b1, -1, '0));
    dir_rows.push_back(xfer_row(CMD_REPLACE, 5'd0, CH_X, 1'b0, -1, '0));
    dir_rows.push_back(xfer_row(CMD_REPLACE, 5'd31, 16'hFFFF, 1'b1, -1, '0));
    dir_rows.push_back(reg_row(REG_SEARCH_LEN, 6'd1));
    dir_rows.push_back(reg_row(REG_REPLACE_LEN, 6'd0));
    // match on the last character with an empty replacement: end marker only
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_A, 1'b1, 1, '{16'h0000, 1'b1, 1'b1}));
    dir_rows.push_back(reg_row(REG_REPLACE_LEN, 6'd1));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd5, CH_B, 1'b0, -1, '0));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_A, 1'b1, -1, '0));
    dir_rows.push_back(xfer_row(CMD_SEARCH, 5'd1, CH_B, 1'b0, -1, '0));
    dir_rows.push_back(reg_row(REG_SEARCH_LEN, 6'd2));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_A, 1'b0, -1, '0));
    // length rewrite mid-path drops the window
    dir_rows.push_back(reg_row(REG_SEARCH_LEN, 6'd2));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_B, 1'b0, -1, '0));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_A, 1'b1, -1, '0));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_A, 1'b0, -1, '0));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_B, 1'b1, -1, '0));
    // replacement flag carried into pass-through mode
    dir_rows.push_back(reg_row(REG_SEARCH_LEN, 6'd1));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_A, 1'b0, -1, '0));
    dir_rows.push_back(reg_row(REG_SEARCH_LEN, 6'd0));
    dir_rows.push_back(xfer_row(CMD_PATH, 5'd0, CH_C, 1'b1, -1, '0));

    seg_pat    = '{3, 32, 1, 63, 0, 0, 2};
    seg_sub    = '{2, 32, 0, 63, 5, 0, 32};
    seg_budget = '{6, 1, 6, 1, 6, 6, 6};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle = 12;
    recv_idle = 75;
    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_item(dir_rows[i].item, dir_rows[i].fixed_n, dir_rows[i].fixed_res);
      end
    end

    // Fill both tables so every length setting compares and emits loaded entries
    for (i = 0; i < TAB_DEPTH; i++) begin
      it = '{CMD_SEARCH, 5'(i), ($urandom_range(1) ? CH_A : CH_B), 1'($urandom)};
      send_item(it, -1, '0);
      it = '{CMD_REPLACE, 5'(i), 16'($urandom), 1'($urandom)};
      send_item(it, -1, '0);
    end

    // Random segments, each under its own length setting
    for (seg = 0; seg < NUM_SEGS; seg++) begin
      wait_idle();
      if (seg == 5) begin
        seg_pat[seg] = $urandom_range(1, 6);
        seg_sub[seg] = $urandom_range(0, 8);
      end
      write_reg(REG_SEARCH_LEN, 6'(seg_pat[seg]));
      write_reg(REG_REPLACE_LEN, 6'(seg_sub[seg]));
      if (seg < 2) begin
        send_idle = 12;
        recv_idle = 75;
      end else if (seg < 4) begin
        send_idle = 75;
        recv_idle = 12;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (seg == 5) stall_requests++;
      used = 0;
      while (used < seg_budget[seg]) begin
        // table reload between paths
        if ($urandom_range(99) < 15) begin
          if ($urandom_range(1))
            it = '{CMD_SEARCH, 5'($urandom), pick_char(), 1'($urandom)};
          else
            it = '{CMD_REPLACE, 5'($urandom), 16'($urandom), 1'($urandom)};
          send_item(it, -1, '0);
          used++;
        end
        send_path(n);
        used += n;
      end
    end

    wait_idle();
    $display("%0d transfers in, %0d characters out checked, %0d paths, %0d with a replacement",
             items_sent, chars_checked, paths_seen, replaced_paths);
    $display("search/replace lengths 0..63 swept, receiver held off %0d cycles once",
             STALL_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### stream_substring_replacer_top.f
rtl/core/ssr_pkg.sv
rtl/core/ssr_cell.sv
rtl/core/ssr_replace_table.sv
rtl/core/ssr_out_queue.sv
rtl/core/stream_substring_replacer_top.sv
rtl/core/ssr_checker.sv
tb/sv/stream_substring_replacer_top_tb.sv
